[design/lptm_pkg.sv]
package lptm_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_OVER_VOLTAGE  = 3'd0;
  localparam logic [2:0] REG_UNDER_VOLTAGE = 3'd1;
  localparam logic [2:0] REG_OVER_CURRENT  = 3'd2;
  localparam logic [2:0] REG_OVER_POWER    = 3'd3;
  localparam logic [2:0] REG_VOLTAGE_BAND  = 3'd4;
  localparam logic [2:0] REG_CURRENT_BAND  = 3'd5;
  localparam logic [2:0] REG_POWER_BAND    = 3'd6;
  localparam logic [2:0] REG_VOLTAGE_FLOOR = 3'd7;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam logic [15:0] VOLTAGE_BAND_RST  = 16'd500;
  localparam logic [15:0] CURRENT_BAND_RST  = 16'd100;
  localparam logic [19:0] POWER_BAND_RST    = 20'd100;
  localparam logic [15:0] VOLTAGE_FLOOR_RST = 16'd5000;

  // Minimum time a trip is held, seconds
  localparam logic [31:0] RECOVER_SECONDS = 32'd10;

  typedef enum logic [2:0] {
    ALARM_OK           = 3'd0,
    ALARM_OVER_VOLTAGE = 3'd1,
    ALARM_UNDER_VOLTAGE = 3'd2,
    ALARM_OVER_CURRENT = 3'd3,
    ALARM_OVER_POWER   = 3'd4
  } alarm_t;

  typedef struct packed {
    logic [15:0] over_voltage_limit;
    logic [15:0] under_voltage_limit;
    logic [15:0] over_current_limit;
    logic [19:0] over_power_limit;
    logic [15:0] voltage_band;
    logic [15:0] current_band;
    logic [19:0] power_band;
    logic [15:0] voltage_floor;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        voltage_cv;
    logic [15:0]        current_ma;
    logic signed [20:0] power_dw;
    logic [31:0]        now_seconds;
  } meas_t;

  typedef struct packed {
    logic        is_tripped;
    alarm_t      active_alarm;
    logic [31:0] trip_time;
  } trip_state_t;

  typedef struct packed {
    alarm_t alarm_code;
    logic   trip_event;
    logic   clear_event;
  } result_t;

endpackage

[design/line_protection_trip_monitor.sv]
// Channel   Direction  Payload (lowest bit first)                     Rate
// s_*       in         voltage_cv, current_ma, power_dw, now_seconds  1 per cycle while s_tready
// m_*       out        alarm_code, trip_event, clear_event            1 per input
// cfg_*     in         register index, write data                    any idle cycle
//
// Each transaction is taken into an input register, evaluated against the trip
// state in one pass of comparators and one 32-bit time subtract, and lands in
// the result register when the result side advances; a new transaction can enter
// every cycle unless m_tready stalls. The trip state is updated on the same edge
// as the result, so the next transaction sees it at once. rst is synchronous and
// clears trip state, valid flags and config registers to defaults. An m_tready
// stall holds the result; intake stops only once input and result regs are full.
module line_protection_trip_monitor import lptm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [15:0] voltage_cv, [31:16] current_ma, [52:32] power_dw,
  // [84:53] now_seconds, [87:85] zero
  input  logic [87:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [2:0] alarm_code, [3] trip_event, [4] clear_event, [7:5] zero
  output logic [7:0]             m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  trip_state_t state;
  trip_state_t state_next;
  meas_t       in_meas;
  logic        in_valid;
  result_t     out_result;
  result_t     result_next;
  logic        out_valid;
  logic        advance;

  // Move the input register on whenever the result register is free or draining
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  // Configuration registers: mask each write to its register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.over_voltage_limit  <= '0;
      cfg.under_voltage_limit <= '0;
      cfg.over_current_limit  <= '0;
      cfg.over_power_limit    <= '0;
      cfg.voltage_band        <= VOLTAGE_BAND_RST;
      cfg.current_band        <= CURRENT_BAND_RST;
      cfg.power_band          <= POWER_BAND_RST;
      cfg.voltage_floor       <= VOLTAGE_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OVER_VOLTAGE:  cfg.over_voltage_limit  <= cfg_data[15:0];
        REG_UNDER_VOLTAGE: cfg.under_voltage_limit <= cfg_data[15:0];
        REG_OVER_CURRENT:  cfg.over_current_limit  <= cfg_data[15:0];
        REG_OVER_POWER:    cfg.over_power_limit    <= cfg_data;
        REG_VOLTAGE_BAND:  cfg.voltage_band        <= cfg_data[15:0];
        REG_CURRENT_BAND:  cfg.current_band        <= cfg_data[15:0];
        REG_POWER_BAND:    cfg.power_band          <= cfg_data;
        REG_VOLTAGE_FLOOR: cfg.voltage_floor       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register: hold while the result side is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_meas.voltage_cv  <= s_tdata[15:0];
      in_meas.current_ma  <= s_tdata[31:16];
      in_meas.power_dw    <= signed'(s_tdata[52:32]);
      in_meas.now_seconds <= s_tdata[84:53];
    end
  end

  lptm_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .meas       (in_meas),
    .state_next (state_next),
    .result     (result_next)
  );

  // Trip state and result register advance together, once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.is_tripped   <= 1'b0;
      state.active_alarm <= ALARM_OK;
      state.trip_time    <= '0;
      out_valid          <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_result.clear_event, out_result.trip_event,
                     out_result.alarm_code};

endmodule

[design/lptm_eval.sv]
module lptm_eval import lptm_pkg::*; (
  input  cfg_t        cfg,
  input  trip_state_t state,
  input  meas_t       meas,
  output trip_state_t state_next,
  output result_t     result
);

  // Widened signed views so a limit minus its band cannot wrap
  logic signed [17:0] volt_s;
  logic signed [17:0] curr_s;
  logic signed [21:0] power_s;
  logic signed [17:0] ov_clear;
  logic signed [17:0] oc_clear;
  logic signed [21:0] op_limit_s;
  logic signed [21:0] op_clear;
  logic [16:0]        uv_clear;
  logic [31:0]        elapsed;
  logic               trip_ov;
  logic               trip_oc;
  logic               trip_op;
  logic               trip_uv;
  logic               gone;
  alarm_t             new_alarm;

  assign volt_s     = signed'({2'b00, meas.voltage_cv});
  assign curr_s     = signed'({2'b00, meas.current_ma});
  assign power_s    = {meas.power_dw[20], meas.power_dw};
  assign ov_clear   = signed'({2'b00, cfg.over_voltage_limit}) -
                      signed'({2'b00, cfg.voltage_band});
  assign oc_clear   = signed'({2'b00, cfg.over_current_limit}) -
                      signed'({2'b00, cfg.current_band});
  assign op_limit_s = signed'({2'b00, cfg.over_power_limit});
  assign op_clear   = op_limit_s - signed'({2'b00, cfg.power_band});
  assign uv_clear   = {1'b0, cfg.under_voltage_limit} + {1'b0, cfg.voltage_band};
  assign elapsed    = meas.now_seconds - state.trip_time;

  assign trip_ov = (cfg.over_voltage_limit != '0) &&
                   (meas.voltage_cv > cfg.over_voltage_limit);
  assign trip_oc = (cfg.over_current_limit != '0) &&
                   (meas.current_ma > cfg.over_current_limit);
  assign trip_op = (cfg.over_power_limit != '0) && (power_s > op_limit_s);
  assign trip_uv = (cfg.under_voltage_limit != '0) &&
                   (meas.voltage_cv < cfg.under_voltage_limit) &&
                   (meas.voltage_cv > cfg.voltage_floor);

  always_comb begin
    priority if (trip_ov) begin
      new_alarm = ALARM_OVER_VOLTAGE;
    end else if (trip_oc) begin
      new_alarm = ALARM_OVER_CURRENT;
    end else if (trip_op) begin
      new_alarm = ALARM_OVER_POWER;
    end else if (trip_uv) begin
      new_alarm = ALARM_UNDER_VOLTAGE;
    end else begin
      new_alarm = ALARM_OK;
    end
  end

  always_comb begin
    unique case (state.active_alarm)
      ALARM_OVER_VOLTAGE: begin
        gone = (cfg.over_voltage_limit == '0) || (volt_s < ov_clear);
      end
      ALARM_UNDER_VOLTAGE: begin
        gone = (cfg.under_voltage_limit == '0) || ({1'b0, meas.voltage_cv} > uv_clear);
      end
      ALARM_OVER_CURRENT: begin
        gone = (cfg.over_current_limit == '0) || (curr_s < oc_clear);
      end
      ALARM_OVER_POWER: begin
        gone = (cfg.over_power_limit == '0) || (power_s < op_clear);
      end
      default: begin
        gone = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next         = state;
    result.trip_event  = 1'b0;
    result.clear_event = 1'b0;
    if (!state.is_tripped) begin
      if (new_alarm != ALARM_OK) begin
        state_next.is_tripped   = 1'b1;
        state_next.active_alarm = new_alarm;
        state_next.trip_time    = meas.now_seconds;
        result.trip_event       = 1'b1;
      end
    end else if (gone && (elapsed >= RECOVER_SECONDS)) begin
      state_next.is_tripped   = 1'b0;
      state_next.active_alarm = ALARM_OK;
      result.clear_event      = 1'b1;
    end
    result.alarm_code = state_next.active_alarm;
  end

endmodule
